@@ src/i2c_master_bit_sequencer_unit_macros.svh @@
// Assertion macros used by the top level of the I2C bit sequencer RTL.
`ifndef I2C_MASTER_BIT_SEQUENCER_UNIT_MACROS_SVH
`define I2C_MASTER_BIT_SEQUENCER_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define I2CBS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define I2CBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/i2cbs_pkg.sv @@
// Package with types, codes and microcode format of the I2C bit sequencer.
`default_nettype none
package i2cbs_pkg;

	localparam int PC_W  = 5;
	localparam int BIT_W = 3;

	typedef logic [PC_W-1:0]  pc_t;
	typedef logic [BIT_W-1:0] bit_idx_t;

	localparam bit_idx_t BIT_LAST = 3'd7;

	typedef enum logic [2:0] {
		OP_START  = 3'd0,
		OP_STOP   = 3'd1,
		OP_WRITE  = 3'd2,
		OP_READ   = 3'd3,
		OP_TX_ACK = 3'd4,
		OP_RX_ACK = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		SCL_KEEP,
		SCL_LOW,
		SCL_HIGH
	} scl_op_t;

	typedef enum logic [2:0] {
		SDA_KEEP,
		SDA_LOW,
		SDA_HIGH,
		SDA_MSB,
		SDA_ACK
	} sda_op_t;

	typedef enum logic [1:0] {
		SH_NONE,
		SH_OUT,
		SH_IN
	} shift_op_t;

	typedef struct packed {
		scl_op_t   scl_op;
		sda_op_t   sda_op;
		shift_op_t shift_op;
		logic      sample;
		logic      rx_emit;
		logic      ack_emit;
		logic      fin;
		logic      lp;
		pc_t       target;
	} cword_t;

	// Microprogram layout.
	localparam pc_t PC_START  = 5'd0;
	localparam pc_t PC_STOP   = 5'd4;
	localparam pc_t PC_WRITE  = 5'd7;
	localparam pc_t PC_WR_LP  = 5'd9;
	localparam pc_t PC_READ   = 5'd10;
	localparam pc_t PC_RD_BIT = 5'd11;
	localparam pc_t PC_RD_LP  = 5'd13;
	localparam pc_t PC_TX_ACK = 5'd14;
	localparam pc_t PC_RX_ACK = 5'd17;
	localparam pc_t PC_END    = 5'd20;

	function automatic pc_t entry_pc(input op_t op);
		pc_t pc;
		case (op)
			OP_START:  pc = PC_START;
			OP_STOP:   pc = PC_STOP;
			OP_WRITE:  pc = PC_WRITE;
			OP_READ:   pc = PC_READ;
			OP_TX_ACK: pc = PC_TX_ACK;
			OP_RX_ACK: pc = PC_RX_ACK;
			default:   pc = PC_START;
		endcase
		return pc;
	endfunction

	function automatic logic op_known(input logic [2:0] op);
		return op inside {OP_START, OP_STOP, OP_WRITE, OP_READ, OP_TX_ACK, OP_RX_ACK};
	endfunction

endpackage
`default_nettype wire

@@ src/i2cbs_cmd_if.sv @@
// Command channel and phase channel interfaces of the I2C bit sequencer.
`default_nettype none
interface i2cbs_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [7:0] tx_byte;
	logic       ack_out;
	logic [7:0] target_byte;
	logic       target_ack;

	modport source (output valid, op, tx_byte, ack_out, target_byte, target_ack,
		input ready);
	modport sink (input valid, op, tx_byte, ack_out, target_byte, target_ack,
		output ready);
endinterface

interface i2cbs_phase_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       sample_phase;
	logic [7:0] rx_data;
	logic       ack_seen;
	logic       last_phase;

	modport source (output valid, scl_level, sda_level, sample_phase, rx_data, ack_seen,
		last_phase, input ready);
	modport sink (input valid, scl_level, sda_level, sample_phase, rx_data, ack_seen,
		last_phase, output ready);
endinterface
`default_nettype wire

@@ src/i2cbs_ucode_rom.sv @@
// Microcode table of the I2C bit sequencer: one control word per step.
`default_nettype none
module i2cbs_ucode_rom (
	input  var i2cbs_pkg::pc_t    pc,
	output i2cbs_pkg::cword_t     cw
);
	import i2cbs_pkg::*;

	function automatic cword_t mk(input scl_op_t sc, input sda_op_t sd, input shift_op_t sh,
		input logic smp, input logic rxe, input logic acke, input logic fn, input logic l,
		input pc_t tgt);
		cword_t w;
		w.scl_op   = sc;
		w.sda_op   = sd;
		w.shift_op = sh;
		w.sample   = smp;
		w.rx_emit  = rxe;
		w.ack_emit = acke;
		w.fin      = fn;
		w.lp       = l;
		w.target   = tgt;
		return w;
	endfunction

	always_comb begin
		case (pc)
			// Start condition.
			5'd0:    cw = mk(SCL_KEEP, SDA_HIGH, SH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
			5'd1:    cw = mk(SCL_HIGH, SDA_KEEP, SH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
			5'd2:    cw = mk(SCL_KEEP, SDA_LOW,  SH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
			5'd3:    cw = mk(SCL_LOW,  SDA_KEEP, SH_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, PC_START);
			// Stop condition.
			5'd4:    cw = mk(SCL_KEEP, SDA_LOW,  SH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
			5'd5:    cw = mk(SCL_HIGH, SDA_KEEP, SH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
			5'd6:    cw = mk(SCL_KEEP, SDA_HIGH, SH_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, PC_START);
			// Byte write, one bit per pass.
			5'd7:    cw = mk(SCL_KEEP, SDA_MSB,  SH_OUT,  1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
			5'd8:    cw = mk(SCL_HIGH, SDA_KEEP, SH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
			PC_WR_LP: cw = mk(SCL_LOW, SDA_KEEP, SH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, PC_WRITE);
			// Byte read, SDA released once, then one bit per pass.
			5'd10:   cw = mk(SCL_KEEP, SDA_HIGH, SH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
			5'd11:   cw = mk(SCL_HIGH, SDA_KEEP, SH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
			5'd12:   cw = mk(SCL_KEEP, SDA_KEEP, SH_IN,   1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
			PC_RD_LP: cw = mk(SCL_LOW, SDA_KEEP, SH_NONE, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, PC_RD_BIT);
			// Send acknowledge.
			5'd14:   cw = mk(SCL_KEEP, SDA_ACK,  SH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
			5'd15:   cw = mk(SCL_HIGH, SDA_KEEP, SH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
			5'd16:   cw = mk(SCL_LOW,  SDA_KEEP, SH_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, PC_START);
			// Receive acknowledge.
			5'd17:   cw = mk(SCL_KEEP, SDA_HIGH, SH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
			5'd18:   cw = mk(SCL_HIGH, SDA_KEEP, SH_NONE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
			5'd19:   cw = mk(SCL_KEEP, SDA_KEEP, SH_NONE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, PC_START);
			5'd20:   cw = mk(SCL_LOW,  SDA_KEEP, SH_NONE, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, PC_START);
			default: cw = mk(SCL_KEEP, SDA_KEEP, SH_NONE, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, PC_START);
		endcase
	end

endmodule
`default_nettype wire

@@ src/i2cbs_datapath.sv @@
// Pin hold registers, shift registers and phase output register of the sequencer.
`default_nettype none
module i2cbs_datapath (
	input  var logic              clk,
	input  var logic              arst_n,
	input  var logic              load,
	input  var logic [2:0]        op,
	input  var logic [7:0]        tx_byte,
	input  var logic              ack_out,
	input  var logic [7:0]        target_byte,
	input  var logic              target_ack,
	input  var logic              step,
	input  var i2cbs_pkg::cword_t cw,
	input  var logic              is_last,
	output logic                  scl_level,
	output logic                  sda_level,
	output logic                  sample_phase,
	output logic [7:0]            rx_data,
	output logic                  ack_seen,
	output logic                  last_phase
);
	import i2cbs_pkg::*;

	logic       scl_hold_q;
	logic       sda_hold_q;
	logic [7:0] data_q;
	logic [7:0] shift_q;
	logic       ack_out_q;
	logic       target_ack_q;
	logic       scl_nx;
	logic       sda_nx;

	always_comb begin
		case (cw.scl_op)
			SCL_LOW:  scl_nx = 1'b0;
			SCL_HIGH: scl_nx = 1'b1;
			default:  scl_nx = scl_hold_q;
		endcase
		case (cw.sda_op)
			SDA_LOW:  sda_nx = 1'b0;
			SDA_HIGH: sda_nx = 1'b1;
			SDA_MSB:  sda_nx = data_q[7];
			SDA_ACK:  sda_nx = ack_out_q;
			default:  sda_nx = sda_hold_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scl_hold_q <= 1'b1;
			sda_hold_q <= 1'b1;
			shift_q    <= '0;
		end else if (load) begin
			shift_q <= '0;
		end else if (step) begin
			scl_hold_q <= scl_nx;
			sda_hold_q <= sda_nx;
			if (cw.shift_op == SH_IN) begin
				shift_q <= {shift_q[6:0], data_q[7]};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q       <= (op == OP_WRITE) ? tx_byte : target_byte;
			ack_out_q    <= ack_out;
			target_ack_q <= target_ack;
		end else if (step && cw.shift_op != SH_NONE) begin
			data_q <= {data_q[6:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			scl_level    <= scl_nx;
			sda_level    <= sda_nx;
			sample_phase <= cw.sample;
			rx_data      <= (cw.rx_emit && is_last) ? shift_q : 8'd0;
			ack_seen     <= cw.ack_emit & target_ack_q;
			last_phase   <= is_last;
		end
	end

endmodule
`default_nettype wire

@@ src/i2c_master_bit_sequencer_unit.sv @@
// Top level of the I2C master bit sequencer: step counter, handshakes, assertions.
//
// The cmd channel takes one bus command per transaction: start, stop, write
// byte, read byte, send ack or receive ack, together with the byte to send, the
// ack level to drive and the levels the target presents on SDA. The phase
// channel returns one transaction per pin phase: SCL level, SDA drive, sample
// mark, and on the final phase the read byte or the sampled ack bit.
// A command runs 3 (stop, send ack), 4 (start, receive ack), 24 (write byte)
// or 25 (read byte) phases. Steps are fetched from a microcode table, one step
// per clock while the phase receiver does not stall. Acceptance loads the step
// counter and the busy flag; each phase then passes through the output register. A new
// command is taken in the cycle after the last phase has been produced.
// Unknown command codes are accepted and produce no phases.
// When the phase receiver stalls, the output register holds its phase and the
// step counter waits; no phase is lost or repeated.
// Reset releases both bus lines (SCL and SDA holds at 1), clears the shift
// register and empties the output register.
`default_nettype none
module i2c_master_bit_sequencer_unit (
	input  var logic     clk,
	input  var logic     arst_n,
	i2cbs_cmd_if.sink    cmd,
	i2cbs_phase_if.source phase
);
	import i2cbs_pkg::*;

	`include "i2c_master_bit_sequencer_unit_macros.svh"

	logic     busy_q;
	logic     out_valid_q;
	pc_t      pc_q;
	bit_idx_t bit_q;
	cword_t   cw;
	logic     accept;
	logic     step;
	logic     is_last;
	logic     loop_back;

	assign cmd.ready = !busy_q;
	assign accept    = cmd.valid && !busy_q;
	assign step      = busy_q && (!out_valid_q || phase.ready);
	assign loop_back = cw.lp && (bit_q != BIT_LAST);
	assign is_last   = cw.fin || (cw.lp && bit_q == BIT_LAST);

	i2cbs_ucode_rom u_rom (
		.pc (pc_q),
		.cw (cw)
	);

	i2cbs_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (accept),
		.op           (cmd.op),
		.tx_byte      (cmd.tx_byte),
		.ack_out      (cmd.ack_out),
		.target_byte  (cmd.target_byte),
		.target_ack   (cmd.target_ack),
		.step         (step),
		.cw           (cw),
		.is_last      (is_last),
		.scl_level    (phase.scl_level),
		.sda_level    (phase.sda_level),
		.sample_phase (phase.sample_phase),
		.rx_data      (phase.rx_data),
		.ack_seen     (phase.ack_seen),
		.last_phase   (phase.last_phase)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= PC_START;
			bit_q  <= '0;
		end else if (accept) begin
			busy_q <= op_known(cmd.op);
			pc_q   <= entry_pc(op_t'(cmd.op));
			bit_q  <= '0;
		end else if (step) begin
			if (is_last) begin
				busy_q <= 1'b0;
			end else if (loop_back) begin
				pc_q  <= cw.target;
				bit_q <= bit_q + 3'd1;
			end else begin
				pc_q <= pc_q + 5'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (phase.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign phase.valid = out_valid_q;

	`I2CBS_ASSERT_NEXT(a_start_busy, accept && op_known(cmd.op), busy_q, "Known command did not start the sequencer.")
	`I2CBS_ASSERT_NEXT(a_last_idle, step && is_last, !busy_q, "Sequencer still busy after the last phase.")
	`I2CBS_ASSERT_NOW(a_pc_range, busy_q, pc_q <= PC_END, "Step counter left the microprogram.")
	`I2CBS_ASSERT_NOW(a_rx_on_last, phase.valid && phase.rx_data != 8'd0, phase.last_phase, "Read byte reported before the last phase.")

endmodule
`default_nettype wire
